// ===== hw/rtl/lcdw_pkg.sv =====
// Shared types and constants of the LCD window pixel byte sequencer.
`timescale 1ns / 1ps

package lcdw_pkg;

    // request kinds
    localparam logic [1:0] KIND_INIT   = 2'd0;
    localparam logic [1:0] KIND_ROTATE = 2'd1;
    localparam logic [1:0] KIND_REGION = 2'd2;
    localparam logic [1:0] KIND_PIXEL  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_PANEL_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_PANEL_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_COL_OFFSET   = 3'd2;
    localparam logic [2:0] CFG_ROW_OFFSET   = 3'd3;
    localparam logic [2:0] CFG_BGR_ORDER    = 3'd4;
    localparam logic [2:0] CFG_INVERT       = 3'd5;

    localparam logic [15:0] RST_PANEL_WIDTH  = 16'd240;
    localparam logic [15:0] RST_PANEL_HEIGHT = 16'd320;

    // status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NOT_INIT    = 4'd1;
    localparam logic [3:0] ST_ZERO_REGION = 4'd2;
    localparam logic [3:0] ST_ORIGIN_OUT  = 4'd3;
    localparam logic [3:0] ST_BEYOND      = 4'd4;
    localparam logic [3:0] ST_OFFSET_OVF  = 4'd5;
    localparam logic [3:0] ST_BAD_ROT     = 4'd6;
    localparam logic [3:0] ST_ZERO_PANEL  = 4'd7;
    localparam logic [3:0] ST_UNEXP_PIXEL = 4'd8;

    // panel command bytes
    localparam logic [7:0] CMD_SWRESET = 8'h01;
    localparam logic [7:0] CMD_SLPOUT  = 8'h11;
    localparam logic [7:0] CMD_NORON   = 8'h13;
    localparam logic [7:0] CMD_INVOFF  = 8'h20;
    localparam logic [7:0] CMD_INVON   = 8'h21;
    localparam logic [7:0] CMD_DISPON  = 8'h29;
    localparam logic [7:0] CMD_CASET   = 8'h2A;
    localparam logic [7:0] CMD_RASET   = 8'h2B;
    localparam logic [7:0] CMD_RAMWR   = 8'h2C;
    localparam logic [7:0] CMD_MADCTL  = 8'h36;
    localparam logic [7:0] CMD_COLMOD  = 8'h3A;
    localparam logic [7:0] DAT_RGB565  = 8'h55;

    // orientation bytes per rotation, BGR bit ORed in
    localparam logic [7:0] ORIENT_ROT0 = 8'hC0;
    localparam logic [7:0] ORIENT_ROT1 = 8'hA0;
    localparam logic [7:0] ORIENT_ROT2 = 8'h00;
    localparam logic [7:0] ORIENT_ROT3 = 8'h60;
    localparam logic [7:0] ORIENT_BGR  = 8'h08;

    // index of the final byte of each job
    localparam logic [3:0] LAST_INIT   = 4'd8;
    localparam logic [3:0] LAST_ROTATE = 4'd1;
    localparam logic [3:0] LAST_REGION = 4'd10;
    localparam logic [3:0] LAST_PIXEL  = 4'd1;
    localparam logic [3:0] LAST_ERROR  = 4'd0;

    typedef enum logic [2:0] {
        JOB_INIT,
        JOB_ROTATE,
        JOB_REGION,
        JOB_PIXEL,
        JOB_ERROR
    } t_job_kind;

    // one decoded request, handed from decode to the byte emitter
    typedef struct packed {
        logic        active;    // job has bytes or an error result to send
        t_job_kind   kind;
        logic [3:0]  last_idx;
        logic [3:0]  status;
        logic [7:0]  orient;
        logic        invert;
        logic [15:0] x0;        // also the pixel value of a pixel job
        logic [15:0] x1;
        logic [15:0] y0;
        logic [15:0] y1;
    } t_job;

    function automatic logic [7:0] orient_byte(input logic [1:0] rot, input logic bgr);
        logic [7:0] base;
        case (rot)
            2'd0:    base = ORIENT_ROT0;
            2'd1:    base = ORIENT_ROT1;
            2'd2:    base = ORIENT_ROT2;
            default: base = ORIENT_ROT3;
        endcase
        return bgr ? (base | ORIENT_BGR) : base;
    endfunction

endpackage

// ===== hw/rtl/lcdw_decode.sv =====
// Request register, configuration registers, panel state and request decode.
`timescale 1ns / 1ps

module lcdw_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_kind,
    input  logic [15:0]     i_origin_x,
    input  logic [15:0]     i_origin_y,
    input  logic [15:0]     i_region_w,
    input  logic [15:0]     i_region_h,
    input  logic [7:0]      i_rotation_value,
    input  logic [15:0]     i_pixel_value,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_job_free,
    output logic            o_job_load,
    output lcdw_pkg::t_job  o_job
);

    // request register
    logic        r_req_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_ox, r_oy, r_rw, r_rh, r_pix;
    logic [7:0]  r_rv;

    // configuration
    logic [15:0] r_panel_w, r_panel_h, r_col_off, r_row_off;
    logic        r_bgr, r_invert;

    // panel state
    logic [1:0]  r_rotation, n_rotation;
    logic        r_ready, n_ready;
    logic [31:0] r_pixels_left, n_pixels_left;

    logic        accept;
    logic [15:0] rot_w, rot_h;
    logic [16:0] end_x, end_y, x0, y0;
    logic [17:0] x1, y1;
    logic [31:0] area;
    lcdw_pkg::t_job n_job;

    assign o_job_load = r_req_valid && i_job_free;
    assign o_stall    = r_req_valid && !i_job_free;
    assign accept     = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (accept) begin
            r_req_valid <= 1'b1;
        end else if (o_job_load) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_ox   <= i_origin_x;
            r_oy   <= i_origin_y;
            r_rw   <= i_region_w;
            r_rh   <= i_region_h;
            r_rv   <= i_rotation_value;
            r_pix  <= i_pixel_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_w <= lcdw_pkg::RST_PANEL_WIDTH;
            r_panel_h <= lcdw_pkg::RST_PANEL_HEIGHT;
            r_col_off <= '0;
            r_row_off <= '0;
            r_bgr     <= 1'b0;
            r_invert  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lcdw_pkg::CFG_PANEL_WIDTH:  r_panel_w <= i_cfg_data;
                lcdw_pkg::CFG_PANEL_HEIGHT: r_panel_h <= i_cfg_data;
                lcdw_pkg::CFG_COL_OFFSET:   r_col_off <= i_cfg_data;
                lcdw_pkg::CFG_ROW_OFFSET:   r_row_off <= i_cfg_data;
                lcdw_pkg::CFG_BGR_ORDER:    r_bgr     <= i_cfg_data[0];
                lcdw_pkg::CFG_INVERT:       r_invert  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation    <= '0;
            r_ready       <= 1'b0;
            r_pixels_left <= '0;
        end else if (o_job_load) begin
            r_rotation    <= n_rotation;
            r_ready       <= n_ready;
            r_pixels_left <= n_pixels_left;
        end
    end

    // window arithmetic, in parallel with the checks
    assign rot_w = r_rotation[0] ? r_panel_h : r_panel_w;
    assign rot_h = r_rotation[0] ? r_panel_w : r_panel_h;
    assign end_x = {1'b0, r_ox} + {1'b0, r_rw};
    assign end_y = {1'b0, r_oy} + {1'b0, r_rh};
    assign x0    = {1'b0, r_ox} + {1'b0, r_col_off};
    assign y0    = {1'b0, r_oy} + {1'b0, r_row_off};
    assign x1    = {1'b0, end_x} - 18'd1 + {2'b0, r_col_off};
    assign y1    = {1'b0, end_y} - 18'd1 + {2'b0, r_row_off};
    assign area  = {16'b0, r_rw} * {16'b0, r_rh};

    always_comb begin
        n_rotation    = r_rotation;
        n_ready       = r_ready;
        n_pixels_left = r_pixels_left;
        n_job          = '0;
        n_job.kind     = lcdw_pkg::JOB_ERROR;
        n_job.last_idx = lcdw_pkg::LAST_ERROR;
        n_job.status   = lcdw_pkg::ST_OK;
        n_job.invert   = r_invert;
        n_job.x0       = x0[15:0];
        n_job.x1       = x1[15:0];
        n_job.y0       = y0[15:0];
        n_job.y1       = y1[15:0];
        case (r_kind)
            lcdw_pkg::KIND_INIT: begin
                n_job.orient = lcdw_pkg::orient_byte(r_rotation, r_bgr);
                if (r_ready) begin
                    n_job.active = 1'b0;
                end else if (r_panel_w == '0 || r_panel_h == '0) begin
                    n_job.active = 1'b1;
                    n_job.status = lcdw_pkg::ST_ZERO_PANEL;
                end else begin
                    n_job.active   = 1'b1;
                    n_job.kind     = lcdw_pkg::JOB_INIT;
                    n_job.last_idx = lcdw_pkg::LAST_INIT;
                    n_ready        = 1'b1;
                end
            end
            lcdw_pkg::KIND_ROTATE: begin
                n_job.orient = lcdw_pkg::orient_byte(r_rv[1:0], r_bgr);
                if (r_rv > 8'd3) begin
                    n_job.active = 1'b1;
                    n_job.status = lcdw_pkg::ST_BAD_ROT;
                end else begin
                    n_rotation     = r_rv[1:0];
                    n_job.active   = r_ready;
                    n_job.kind     = lcdw_pkg::JOB_ROTATE;
                    n_job.last_idx = lcdw_pkg::LAST_ROTATE;
                end
            end
            lcdw_pkg::KIND_REGION: begin
                n_job.active = 1'b1;
                if (!r_ready) begin
                    n_job.status = lcdw_pkg::ST_NOT_INIT;
                end else if (r_rw == '0 || r_rh == '0) begin
                    n_job.status = lcdw_pkg::ST_ZERO_REGION;
                end else if (r_ox >= rot_w || r_oy >= rot_h) begin
                    n_job.status = lcdw_pkg::ST_ORIGIN_OUT;
                end else if (end_x > {1'b0, rot_w} || end_y > {1'b0, rot_h}) begin
                    n_job.status = lcdw_pkg::ST_BEYOND;
                end else if (x0[16] || y0[16] || x1[17:16] != 2'b00
                             || y1[17:16] != 2'b00) begin
                    n_job.status = lcdw_pkg::ST_OFFSET_OVF;
                end else begin
                    n_job.kind     = lcdw_pkg::JOB_REGION;
                    n_job.last_idx = lcdw_pkg::LAST_REGION;
                    n_pixels_left  = area;
                end
            end
            default: begin
                n_job.active = 1'b1;
                n_job.x0     = r_pix;
                if (r_pixels_left == '0) begin
                    n_job.status = lcdw_pkg::ST_UNEXP_PIXEL;
                end else begin
                    n_job.kind     = lcdw_pkg::JOB_PIXEL;
                    n_job.last_idx = lcdw_pkg::LAST_PIXEL;
                    n_pixels_left  = r_pixels_left - 32'd1;
                end
            end
        endcase
    end

    assign o_job = n_job;

endmodule

// ===== hw/rtl/lcdw_emit.sv =====
// Job register, byte walker and output register.
`timescale 1ns / 1ps

module lcdw_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_load,
    input  lcdw_pkg::t_job  i_job,
    output logic            o_job_free,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_bus_byte,
    output logic            o_is_data,
    output logic            o_byte_valid,
    output logic            o_last,
    output logic [3:0]      o_status
);

    lcdw_pkg::t_job r_job;
    logic           r_job_valid;
    logic [3:0]     r_idx;

    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_out_data, r_out_bvalid, r_out_last;
    logic [3:0]     r_out_status;

    logic           out_ok, fire, done;
    logic [7:0]     cur_byte;
    logic           cur_data;

    assign out_ok     = !r_out_valid || !i_stall;
    assign fire       = r_job_valid && out_ok;
    assign done       = fire && (r_idx == r_job.last_idx);
    assign o_job_free = !r_job_valid || done;

    // byte and D/C level for the current position of the job
    always_comb begin
        cur_byte = 8'h00;
        cur_data = 1'b0;
        case (r_job.kind)
            lcdw_pkg::JOB_INIT: begin
                case (r_idx)
                    4'd0: cur_byte = lcdw_pkg::CMD_SWRESET;
                    4'd1: cur_byte = lcdw_pkg::CMD_SLPOUT;
                    4'd2: cur_byte = lcdw_pkg::CMD_COLMOD;
                    4'd3: begin
                        cur_byte = lcdw_pkg::DAT_RGB565;
                        cur_data = 1'b1;
                    end
                    4'd4: cur_byte = lcdw_pkg::CMD_MADCTL;
                    4'd5: begin
                        cur_byte = r_job.orient;
                        cur_data = 1'b1;
                    end
                    4'd6: cur_byte = r_job.invert ? lcdw_pkg::CMD_INVON
                                                  : lcdw_pkg::CMD_INVOFF;
                    4'd7: cur_byte = lcdw_pkg::CMD_NORON;
                    default: cur_byte = lcdw_pkg::CMD_DISPON;
                endcase
            end
            lcdw_pkg::JOB_ROTATE: begin
                if (r_idx == 4'd0) begin
                    cur_byte = lcdw_pkg::CMD_MADCTL;
                end else begin
                    cur_byte = r_job.orient;
                    cur_data = 1'b1;
                end
            end
            lcdw_pkg::JOB_REGION: begin
                cur_data = 1'b1;
                case (r_idx)
                    4'd0: begin
                        cur_byte = lcdw_pkg::CMD_CASET;
                        cur_data = 1'b0;
                    end
                    4'd1: cur_byte = r_job.x0[15:8];
                    4'd2: cur_byte = r_job.x0[7:0];
                    4'd3: cur_byte = r_job.x1[15:8];
                    4'd4: cur_byte = r_job.x1[7:0];
                    4'd5: begin
                        cur_byte = lcdw_pkg::CMD_RASET;
                        cur_data = 1'b0;
                    end
                    4'd6: cur_byte = r_job.y0[15:8];
                    4'd7: cur_byte = r_job.y0[7:0];
                    4'd8: cur_byte = r_job.y1[15:8];
                    4'd9: cur_byte = r_job.y1[7:0];
                    default: begin
                        cur_byte = lcdw_pkg::CMD_RAMWR;
                        cur_data = 1'b0;
                    end
                endcase
            end
            lcdw_pkg::JOB_PIXEL: begin
                cur_data = 1'b1;
                cur_byte = (r_idx == 4'd0) ? r_job.x0[15:8] : r_job.x0[7:0];
            end
            default: begin
                cur_byte = 8'h00;
                cur_data = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
        end else if (i_job_load) begin
            r_job_valid <= i_job.active;
            r_idx       <= '0;
        end else if (fire) begin
            r_idx <= r_idx + 4'd1;
            if (done) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_load) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ok) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_byte   <= cur_byte;
            r_out_data   <= cur_data;
            r_out_bvalid <= (r_job.kind != lcdw_pkg::JOB_ERROR);
            r_out_last   <= (r_idx == r_job.last_idx);
            r_out_status <= r_job.status;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_bus_byte   = r_out_byte;
    assign o_is_data    = r_out_data;
    assign o_byte_valid = r_out_bvalid;
    assign o_last       = r_out_last;
    assign o_status     = r_out_status;

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> r_idx <= r_job.last_idx)
        else $error("byte index ran past end of job");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_bvalid |-> r_out_last && r_out_status != lcdw_pkg::ST_OK)
        else $error("error result not single or without status");

    a_mid_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> r_job_valid)
        else $error("non-final byte pending but job released");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_load |-> o_job_free)
        else $error("job loaded over a busy job");

endmodule

// ===== hw/rtl/lcd_window_pixel_byte_sequencer.sv =====
// Top level of the LCD window pixel byte sequencer.
`timescale 1ns / 1ps

// Turns display requests (init, rotation, region, pixel) into serial-bus bytes
// tagged command or data, one byte per output request per cycle while the
// output is not stalled. A request passes a request register, is decoded
// combinationally against the panel state into a job, and the job is walked
// one byte a cycle into the output register while the output is not stalled.
// Bytes per request: init 9 (none once initialized), rotation 2 (none before
// init), region 11, pixel 2 (high byte first); a rejected request gives one
// result with byte_valid low and a status code. A new request is decoded in
// the same cycle its predecessor's last byte leaves. The input side keeps
// accepting while a finished byte waits on a stalled output, until the job
// and request registers are both full. Configuration registers (index: 0 panel
// width, 1 panel height, 2 column offset, 3 row offset, 4 BGR order, 5
// inversion) are to be written only while idle; the block does not enforce it.

module lcd_window_pixel_byte_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_origin_x,
    input  logic [15:0] i_origin_y,
    input  logic [15:0] i_region_w,
    input  logic [15:0] i_region_h,
    input  logic [7:0]  i_rotation_value,
    input  logic [15:0] i_pixel_value,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_bus_byte,
    output logic        o_is_data,
    output logic        o_byte_valid,
    output logic        o_last,
    output logic [3:0]  o_status
);

    logic           job_free;
    logic           job_load;
    lcdw_pkg::t_job job;

    // decode owns the request register and all panel state
    lcdw_decode u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_origin_x       (i_origin_x),
        .i_origin_y       (i_origin_y),
        .i_region_w       (i_region_w),
        .i_region_h       (i_region_h),
        .i_rotation_value (i_rotation_value),
        .i_pixel_value    (i_pixel_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_job_free       (job_free),
        .o_job_load       (job_load),
        .o_job            (job)
    );

    // emitter walks the job bytes into the output register
    lcdw_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_load   (job_load),
        .i_job        (job),
        .o_job_free   (job_free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_bus_byte   (o_bus_byte),
        .o_is_data    (o_is_data),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_status     (o_status)
    );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the LCD window pixel byte sequencer.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF       = 6;     // 12 ns period
    localparam int SETTLE_CYCLES  = 8;     // covers decode and emit latency of a silent request
    localparam int HOLD_CYCLES    = 150;   // long receiver hold-off for the pressure test
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side

    // one request as the sender sees it
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [15:0] region_w;
        logic [15:0] region_h;
        logic [7:0]  rotation_value;
        logic [15:0] pixel_value;
    } t_lcd_req;

    // one bus byte as the receiver sees it
    typedef struct {
        logic [7:0] bus_byte;
        logic       is_data;
        logic       byte_valid;
        logic       last;
        logic [3:0] status;
    } t_bus_rec;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_kind;
    logic [15:0] i_origin_x;
    logic [15:0] i_origin_y;
    logic [15:0] i_region_w;
    logic [15:0] i_region_h;
    logic [7:0]  i_rotation_value;
    logic [15:0] i_pixel_value;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_bus_byte;
    logic        o_is_data;
    logic        o_byte_valid;
    logic        o_last;
    logic [3:0]  o_status;

    lcd_window_pixel_byte_sequencer dut (.*);

    // ---------------------------------------------------------------
    // Panel model: registers and state as the block should hold them
    // ---------------------------------------------------------------
    logic [15:0] m_width      = lcdw_pkg::RST_PANEL_WIDTH;
    logic [15:0] m_height     = lcdw_pkg::RST_PANEL_HEIGHT;
    logic [15:0] m_col_off    = 16'd0;
    logic [15:0] m_row_off    = 16'd0;
    logic        m_bgr        = 1'b0;
    logic        m_invert     = 1'b0;
    logic [1:0]  m_rot        = 2'd0;
    logic        m_ready      = 1'b0;
    logic [31:0] m_pixels_left = 32'd0;

    t_bus_rec bytes_due[$];   // bus bytes predicted but not yet seen
    int       errors = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    bit       hold_off = 1'b0;
    int       quiet_cycles = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Byte prediction
    // ---------------------------------------------------------------
    function void push_byte(input logic [7:0] b, input logic is_data);
        t_bus_rec rec;
        rec.bus_byte   = b;
        rec.is_data    = is_data;
        rec.byte_valid = 1'b1;
        rec.last       = 1'b0;
        rec.status     = lcdw_pkg::ST_OK;
        bytes_due.push_back(rec);
    endfunction

    // a rejected request: one result, no byte to send
    function void push_error(input logic [3:0] code);
        t_bus_rec rec;
        rec.bus_byte   = 8'h00;
        rec.is_data    = 1'b0;
        rec.byte_valid = 1'b0;
        rec.last       = 1'b1;
        rec.status     = code;
        bytes_due.push_back(rec);
    endfunction

    // tag the newest byte as the final one of its request
    function void close_request();
        t_bus_rec rec;
        rec = bytes_due.pop_back();
        rec.last = 1'b1;
        bytes_due.push_back(rec);
    endfunction

    function logic [7:0] orient_for(input logic [1:0] rot);
        logic [7:0] tab [4];
        tab = '{lcdw_pkg::ORIENT_ROT0, lcdw_pkg::ORIENT_ROT1,
                lcdw_pkg::ORIENT_ROT2, lcdw_pkg::ORIENT_ROT3};
        return tab[rot] | (m_bgr ? lcdw_pkg::ORIENT_BGR : 8'h00);
    endfunction

    // Work out the bus bytes of one accepted request and advance the model.
    function void predict_bytes(input t_lcd_req r);
        logic [31:0] w_lim, h_lim, x0, x1, y0, y1;
        // rotated window bounds: odd rotations swap the panel axes
        w_lim = m_rot[0] ? 32'(m_height) : 32'(m_width);
        h_lim = m_rot[0] ? 32'(m_width) : 32'(m_height);
        x0 = 32'(r.origin_x) + 32'(m_col_off);
        x1 = x0 + 32'(r.region_w) - 32'd1;
        y0 = 32'(r.origin_y) + 32'(m_row_off);
        y1 = y0 + 32'(r.region_h) - 32'd1;

        if (r.kind == lcdw_pkg::KIND_INIT) begin
            if (m_ready)
                return;   // already up: silently dropped
            if (m_width == 16'd0 || m_height == 16'd0) begin
                push_error(lcdw_pkg::ST_ZERO_PANEL);
                return;
            end
            push_byte(lcdw_pkg::CMD_SWRESET, 1'b0);
            push_byte(lcdw_pkg::CMD_SLPOUT, 1'b0);
            push_byte(lcdw_pkg::CMD_COLMOD, 1'b0);
            push_byte(lcdw_pkg::DAT_RGB565, 1'b1);
            push_byte(lcdw_pkg::CMD_MADCTL, 1'b0);
            push_byte(orient_for(m_rot), 1'b1);
            push_byte(m_invert ? lcdw_pkg::CMD_INVON : lcdw_pkg::CMD_INVOFF, 1'b0);
            push_byte(lcdw_pkg::CMD_NORON, 1'b0);
            push_byte(lcdw_pkg::CMD_DISPON, 1'b0);
            close_request();
            m_ready = 1'b1;
        end else if (r.kind == lcdw_pkg::KIND_ROTATE) begin
            if (r.rotation_value > 8'd3) begin
                push_error(lcdw_pkg::ST_BAD_ROT);
                return;
            end
            m_rot = r.rotation_value[1:0];
            if (!m_ready)
                return;   // stored for init, nothing sent
            push_byte(lcdw_pkg::CMD_MADCTL, 1'b0);
            push_byte(orient_for(m_rot), 1'b1);
            close_request();
        end else if (r.kind == lcdw_pkg::KIND_REGION) begin
            // first failing check wins
            if (!m_ready)
                push_error(lcdw_pkg::ST_NOT_INIT);
            else if (r.region_w == 16'd0 || r.region_h == 16'd0)
                push_error(lcdw_pkg::ST_ZERO_REGION);
            else if (32'(r.origin_x) >= w_lim || 32'(r.origin_y) >= h_lim)
                push_error(lcdw_pkg::ST_ORIGIN_OUT);
            else if (32'(r.origin_x) + 32'(r.region_w) > w_lim ||
                     32'(r.origin_y) + 32'(r.region_h) > h_lim)
                push_error(lcdw_pkg::ST_BEYOND);
            else if (x0 > 32'hFFFF || x1 > 32'hFFFF ||
                     y0 > 32'hFFFF || y1 > 32'hFFFF)
                push_error(lcdw_pkg::ST_OFFSET_OVF);
            else begin
                push_byte(lcdw_pkg::CMD_CASET, 1'b0);
                push_byte(x0[15:8], 1'b1);
                push_byte(x0[7:0], 1'b1);
                push_byte(x1[15:8], 1'b1);
                push_byte(x1[7:0], 1'b1);
                push_byte(lcdw_pkg::CMD_RASET, 1'b0);
                push_byte(y0[15:8], 1'b1);
                push_byte(y0[7:0], 1'b1);
                push_byte(y1[15:8], 1'b1);
                push_byte(y1[7:0], 1'b1);
                push_byte(lcdw_pkg::CMD_RAMWR, 1'b0);
                close_request();
                // a new window replaces whatever count was left
                m_pixels_left = 32'(r.region_w) * 32'(r.region_h);
            end
        end else begin
            if (m_pixels_left == 32'd0) begin
                push_error(lcdw_pkg::ST_UNEXP_PIXEL);
                return;
            end
            // RGB565, high byte first
            push_byte(r.pixel_value[15:8], 1'b1);
            push_byte(r.pixel_value[7:0], 1'b1);
            close_request();
            m_pixels_left = m_pixels_left - 32'd1;
        end
    endfunction

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    function automatic t_lcd_req make_req(input logic [1:0] kind, input logic [15:0] ox,
                                          input logic [15:0] oy, input logic [15:0] rw,
                                          input logic [15:0] rh, input logic [7:0] rv,
                                          input logic [15:0] pv);
        t_lcd_req r;
        r.kind           = kind;
        r.origin_x       = ox;
        r.origin_y       = oy;
        r.region_w       = rw;
        r.region_h       = rh;
        r.rotation_value = rv;
        r.pixel_value    = pv;
        return r;
    endfunction

    // Offer one request, hold it until taken, then maybe go idle a while.
    // Valid is only lowered when a gap follows, so it never toggles within a step.
    task automatic send_req(input t_lcd_req r);
        i_valid          <= 1'b1;
        i_kind           <= r.kind;
        i_origin_x       <= r.origin_x;
        i_origin_y       <= r.origin_y;
        i_region_w       <= r.region_w;
        i_region_h       <= r.region_h;
        i_rotation_value <= r.rotation_value;
        i_pixel_value    <= r.pixel_value;
        do @(posedge i_clk); while (o_stall);
        predict_bytes(r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stop offering, wait for every predicted byte, then let silent
    // requests still in the pipe fall through.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            lcdw_pkg::CFG_PANEL_WIDTH:  m_width   = val;
            lcdw_pkg::CFG_PANEL_HEIGHT: m_height  = val;
            lcdw_pkg::CFG_COL_OFFSET:   m_col_off = val;
            lcdw_pkg::CFG_ROW_OFFSET:   m_row_off = val;
            lcdw_pkg::CFG_BGR_ORDER:    m_bgr     = val[0];
            lcdw_pkg::CFG_INVERT:       m_invert  = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // full register set, only ever written with the block idle
    task automatic panel_setup(input logic [15:0] w, input logic [15:0] h,
                               input logic [15:0] col, input logic [15:0] row,
                               input logic bgr, input logic inv);
        drain_pipeline();
        write_reg(lcdw_pkg::CFG_PANEL_WIDTH, w);
        write_reg(lcdw_pkg::CFG_PANEL_HEIGHT, h);
        write_reg(lcdw_pkg::CFG_COL_OFFSET, col);
        write_reg(lcdw_pkg::CFG_ROW_OFFSET, row);
        write_reg(lcdw_pkg::CFG_BGR_ORDER, {15'd0, bgr});
        write_reg(lcdw_pkg::CFG_INVERT, {15'd0, inv});
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Mostly well-formed traffic: windows that fit, followed by pixels;
    // the rest is rotation changes and fully random noise.
    function automatic t_lcd_req rand_request();
        t_lcd_req    r;
        int unsigned pick, w_lim, h_lim, avail;
        r.kind           = 2'($urandom_range(3, 0));
        r.origin_x       = 16'($urandom);
        r.origin_y       = 16'($urandom);
        r.region_w       = 16'($urandom);
        r.region_h       = 16'($urandom);
        r.rotation_value = 8'($urandom);
        r.pixel_value    = 16'($urandom);
        w_lim = m_rot[0] ? 32'(m_height) : 32'(m_width);
        h_lim = m_rot[0] ? 32'(m_width) : 32'(m_height);
        pick  = $urandom_range(99);
        if (pick < 15) begin
            // noise: all fields random
        end else if (pick < 25) begin
            r.kind = lcdw_pkg::KIND_ROTATE;
            if ($urandom_range(9) != 0)
                r.rotation_value = 8'($urandom_range(3));
        end else if (pick < 45 && w_lim != 0 && h_lim != 0) begin
            r.kind     = lcdw_pkg::KIND_REGION;
            r.origin_x = 16'($urandom_range(w_lim - 1));
            r.origin_y = 16'($urandom_range(h_lim - 1));
            avail      = w_lim - 32'(r.origin_x);
            r.region_w = 16'($urandom_range(avail < 3 ? avail : 3, 1));
            avail      = h_lim - 32'(r.origin_y);
            r.region_h = 16'($urandom_range(avail < 3 ? avail : 3, 1));
        end else begin
            r.kind = lcdw_pkg::KIND_PIXEL;
        end
        return r;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_req(rand_request());
    endtask

    // ---------------------------------------------------------------
    // Receiver side: random stall, or a long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    function void check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // every byte taken is held against the oldest prediction
    always @(posedge i_clk) begin
        t_bus_rec want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (bytes_due.size() == 0) begin
                $display("%0t ns: unexpected byte, expected none, got %0h/%0b/%0b/%0b/%0d",
                         $time, o_bus_byte, o_is_data, o_byte_valid, o_last, o_status);
                errors++;
            end else begin
                want = bytes_due.pop_front();
                check_field("bus_byte", want.bus_byte, o_bus_byte);
                check_field("is_data", {7'd0, want.is_data}, {7'd0, o_is_data});
                check_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, o_byte_valid});
                check_field("last", {7'd0, want.last}, {7'd0, o_last});
                check_field("status", {4'd0, want.status}, {4'd0, o_status});
            end
        end
    end

    // watchdog: no handshake on either side for too long ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Before init: stray pixel, early window, bad and stored rotation,
    // and init refused on a zero panel dimension.
    task automatic test_before_init();
        set_idling(0, 0);
        send_req(make_req(lcdw_pkg::KIND_PIXEL, '0, '0, '0, '0, '0, 16'h1234));
        send_req(make_req(lcdw_pkg::KIND_REGION, '0, '0, 16'd1, 16'd1, '0, '0));
        send_req(make_req(lcdw_pkg::KIND_ROTATE, '0, '0, '0, '0, 8'hFF, '0));
        send_req(make_req(lcdw_pkg::KIND_ROTATE, '0, '0, '0, '0, 8'd1, '0));  // stored, silent
        panel_setup(16'd0, 16'd320, '0, '0, 1'b1, 1'b1);
        send_req(make_req(lcdw_pkg::KIND_INIT, '0, '0, '0, '0, '0, '0));
        panel_setup(16'd240, 16'd0, '0, '0, 1'b1, 1'b1);
        send_req(make_req(lcdw_pkg::KIND_INIT, '0, '0, '0, '0, '0, '0));
    endtask

    // start-up sequence with inversion on, BGR and the stored rotation;
    // a second init is swallowed
    task automatic test_init();
        panel_setup(16'd240, 16'd320, '0, '0, 1'b1, 1'b1);
        send_req(make_req(lcdw_pkg::KIND_INIT, '0, '0, '0, '0, '0, '0));
        send_req(make_req(lcdw_pkg::KIND_INIT, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 8'hFF, 16'hFFFF));
    endtask

    task automatic test_rotation();
        send_req(make_req(lcdw_pkg::KIND_ROTATE, '0, '0, '0, '0, 8'd3, '0));
        send_req(make_req(lcdw_pkg::KIND_ROTATE, '0, '0, '0, '0, 8'd0, '0));
        send_req(make_req(lcdw_pkg::KIND_ROTATE, '0, '0, '0, '0, 8'd4, '0));
        send_req(make_req(lcdw_pkg::KIND_ROTATE, '0, '0, '0, '0, 8'd2, '0));
    endtask

    // window checks in their priority order, the largest legal window,
    // and address overflow once a column offset is added
    task automatic test_region_checks();
        send_req(make_req(lcdw_pkg::KIND_REGION, '0, '0, '0, 16'd5, '0, '0));
        send_req(make_req(lcdw_pkg::KIND_REGION, '0, '0, 16'd5, '0, '0, '0));
        send_req(make_req(lcdw_pkg::KIND_REGION, 16'hFFFF, '0, 16'd1, 16'd1, '0, '0));
        send_req(make_req(lcdw_pkg::KIND_REGION, '0, 16'd320, 16'd1, 16'd1, '0, '0));
        send_req(make_req(lcdw_pkg::KIND_REGION, '0, '0, 16'hFFFF, 16'd1, '0, '0));
        send_req(make_req(lcdw_pkg::KIND_REGION, '0, '0, 16'd240, 16'd320, '0, '0));
        panel_setup(16'd240, 16'd320, 16'hFFFF, '0, 1'b0, 1'b0);
        // lands exactly on 0xFFFF, then one past
        send_req(make_req(lcdw_pkg::KIND_REGION, '0, '0, 16'd1, 16'd1, '0, '0));
        send_req(make_req(lcdw_pkg::KIND_REGION, '0, '0, 16'd2, 16'd1, '0, '0));
    endtask

    // a two-pixel window, pixel extremes, then one pixel too many
    task automatic test_pixel_stream();
        panel_setup(16'd240, 16'd320, 16'h0100, 16'h0203, 1'b0, 1'b0);
        send_req(make_req(lcdw_pkg::KIND_REGION, 16'd7, 16'd9, 16'd2, 16'd1, '0, '0));
        send_req(make_req(lcdw_pkg::KIND_PIXEL, '0, '0, '0, '0, '0, 16'h0000));
        send_req(make_req(lcdw_pkg::KIND_PIXEL, '0, '0, '0, '0, '0, 16'hFFFF));
        send_req(make_req(lcdw_pkg::KIND_PIXEL, '0, '0, '0, '0, '0, 16'hA5C3));
    endtask

    // receiver holds off while pixels for the window keep coming,
    // so the block fills and must stall its input
    task automatic test_backpressure();
        int i;
        panel_setup(16'd240, 16'd320, '0, '0, 1'b0, 1'b0);
        set_idling(0, 0);
        hold_off = 1'b1;
        send_req(make_req(lcdw_pkg::KIND_REGION, 16'd10, 16'd20, 16'd8, 16'd4, '0, '0));
        for (i = 0; i < 30; i++)
            send_req(make_req(lcdw_pkg::KIND_PIXEL, '0, '0, '0, '0, '0, 16'($urandom)));
        drain_pipeline();
    endtask

    // random traffic across register settings and idling patterns
    task automatic test_random_traffic();
        panel_setup(16'd240, 16'd320, '0, '0, 1'b0, 1'b0);
        set_idling(0, 0);
        run_random(18);
        panel_setup(16'd1, 16'd1, 16'hFFFF, '0, 1'b1, 1'b1);
        set_idling(72, 0);
        run_random(18);
        panel_setup(16'hFFFF, 16'hFFFF, 16'd1, '0, 1'b0, 1'b1);
        set_idling(0, 72);
        run_random(18);
        panel_setup(16'($urandom_range(400, 1)), 16'($urandom_range(400, 1)),
                    16'($urandom_range(1000)), 16'($urandom_range(1000)),
                    1'($urandom), 1'($urandom));
        set_idling(24, 24);
        run_random(18);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_kind           = lcdw_pkg::KIND_INIT;
        i_origin_x       = 16'd0;
        i_origin_y       = 16'd0;
        i_region_w       = 16'd0;
        i_region_h       = 16'd0;
        i_rotation_value = 8'd0;
        i_pixel_value    = 16'd0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = lcdw_pkg::CFG_PANEL_WIDTH;
        i_cfg_data       = 16'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_init();
        test_init();
        test_rotation();
        test_region_checks();
        test_pixel_stream();
        test_backpressure();
        test_random_traffic();
        drain_pipeline();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lcdw_pkg.sv
hw/rtl/lcdw_decode.sv
hw/rtl/lcdw_emit.sv
hw/rtl/lcd_window_pixel_byte_sequencer.sv
verif/tb.sv
